/* design/sorted_value_list_assert.svh */
// Assertion macros for the sorted value list controller
`ifndef SORTED_VALUE_LIST_ASSERT_SVH
`define SORTED_VALUE_LIST_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define SVL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high
`define SVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/svl_pkg.sv */
package svl_pkg;

   // Storage geometry
   localparam int CAPACITY      = 16;
   localparam int DATA_W        = 32;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int COUNT_FIELD_W = 5;
   localparam int STATUS_W      = 2;

   // Request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_CMP,
      FSM_UPD
   } fsm_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic                     compare;
      logic                     update;
      logic                     mode;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   // Signals handed from one cell to its right-hand neighbour
   typedef struct packed {
      logic                     ins;    // insert point at or before this cell
      logic                     seen;   // first equal entry at or before this cell
      logic signed [DATA_W-1:0] entry;
   } link_type;

   // Count masked to the width of the response field
   function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+COUNT_FIELD_W-1:0] wide;
      wide = {{COUNT_FIELD_W{1'b0}}, cnt};
      return wide[COUNT_FIELD_W-1:0];
   endfunction

endpackage

/* design/svl_cell.sv */
module svl_cell (
   input  logic                             clock,
   input  svl_pkg::cell_cmd_type            cmd,
   input  logic                             valid,
   input  logic                             is_head,
   input  svl_pkg::link_type                left,
   input  logic signed [svl_pkg::DATA_W-1:0] right_entry,
   output svl_pkg::link_type                to_right
);
   import svl_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     ins_ff, ins_in;
   logic                     eq_ff, eq_in;
   logic                     seen;

   // Compare phase: local ordering and equality against the request value
   always_comb begin
      if (!valid) begin
         ins_in = 1'b1;
      end else if (is_head) begin
         ins_in = entry_ff > cmd.value;
      end else begin
         ins_in = entry_ff >= cmd.value;
      end
      eq_in = valid && (entry_ff == cmd.value);
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         ins_ff <= ins_in;
         eq_ff  <= eq_in;
      end
   end

   // Chain of first-match flags for delete
   assign seen = left.seen | eq_ff;

   // Update phase: shift right on insert, shift left on delete
   always_comb begin
      entry_in = entry_ff;
      if (cmd.mode == MODE_INSERT) begin
         if (left.ins) begin
            entry_in = left.entry;
         end else if (ins_ff) begin
            entry_in = cmd.value;
         end
      end else begin
         if (seen) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         entry_ff <= entry_in;
      end
   end

   assign to_right.ins   = ins_ff;
   assign to_right.seen  = seen;
   assign to_right.entry = entry_ff;

endmodule

/* design/svl_ctrl.sv */
`include "sorted_value_list_assert.svh"

module svl_ctrl (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic signed [svl_pkg::DATA_W-1:0]       req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [svl_pkg::STATUS_W-1:0]            rsp_status,
   output logic [svl_pkg::COUNT_FIELD_W-1:0]       rsp_count,
   input  logic                                    found,
   output svl_pkg::cell_cmd_type                   cmd,
   output logic [svl_pkg::CNT_W-1:0]               count
);
   import svl_pkg::*;

   fsm_type                  state_ff, state_in;
   logic                     mode_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff, status_in;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff;
   logic                     full;
   logic                     upd_go;
   logic                     cmp_go;
   logic                     accept;

   assign full   = count_ff == CNT_W'(CAPACITY);
   assign accept = req_valid && req_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (req_valid) state_in = FSM_CMP;
         FSM_CMP:  state_in = FSM_UPD;
         FSM_UPD:  if (!rsp_valid_ff || rsp_ready) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      upd_go    = 1'b0;
      cmp_go    = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_ready = 1'b1;
         FSM_CMP:  cmp_go = 1'b1;
         FSM_UPD:  upd_go = !rsp_valid_ff || rsp_ready;
         default:  req_ready = 1'b0;
      endcase
   end

   // Cells move only when the request changes the store
   assign cmd.compare = cmp_go;
   assign cmd.update  = upd_go && !(mode_ff == MODE_INSERT && full);
   assign cmd.mode    = mode_ff;
   assign cmd.value   = value_ff;

   // Status and new count
   always_comb begin
      count_in  = count_ff;
      status_in = ST_INSERTED;
      if (mode_ff == MODE_INSERT) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            count_in  = count_ff + CNT_W'(1);
         end
      end else begin
         if (found) begin
            status_in = ST_DELETED;
            count_in  = count_ff - CNT_W'(1);
         end else begin
            status_in = ST_NOT_FOUND;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (upd_go) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
      if (upd_go) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= count_field(count_in);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;
   assign count      = count_ff;

   `SVL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `SVL_ASSERT_NEXT(a_full_refused, clock, reset, upd_go && mode_ff == MODE_INSERT && full,
      $stable(count_ff) && rsp_status_ff == ST_FULL, "insert into full store changed count")
   `SVL_ASSERT_NEXT(a_accept_to_cmp, clock, reset, accept, state_ff == FSM_CMP,
      "accepted request did not enter compare")
   `SVL_ASSERT_NEXT(a_notfound_stable, clock, reset,
      upd_go && mode_ff == MODE_DELETE && !found, $stable(count_ff),
      "failed delete changed count")

endmodule

/* design/sorted_value_list.sv */
// Sorted store of up to CAPACITY signed 32-bit values, ascending. Each request
// inserts a value at its sorted place (a value equal to the head goes after it)
// or deletes the first equal entry, and returns one response with a status
// (inserted, deleted, not found, full) and the entry count after the request.
// The store is a row of cells, one entry each. A request passes through
// acceptance, a compare state in which every cell checks its entry against the
// value in parallel, and an update state in which the insert point and the
// first-match flag ripple along the row and each cell loads from itself, its
// left or its right neighbour. A request can be accepted while the previous
// response waits; its update then holds until that response is taken.
module sorted_value_list (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic signed [svl_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [svl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [svl_pkg::COUNT_FIELD_W-1:0]  rsp_count
);
   import svl_pkg::*;

   cell_cmd_type     cmd;
   logic [CNT_W-1:0] count;
   logic             found;
   link_type         links [CAPACITY+1];
   logic [CAPACITY-1:0] cell_valid;

   svl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .found      (found),
      .cmd        (cmd),
      .count      (count)
   );

   // Left edge of the row: no insert point and no match yet
   assign links[0] = '0;
   assign found    = links[CAPACITY].seen;

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] right_entry;

      assign cell_valid[i] = count > CNT_W'(i);

      if (i < CAPACITY - 1) begin : g_inner
         assign right_entry = links[i+2].entry;
      end else begin : g_last
         assign right_entry = '0;
      end

      svl_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .valid       (cell_valid[i]),
         .is_head     (1'(i == 0)),
         .left        (links[i]),
         .right_entry (right_entry),
         .to_right    (links[i+1])
      );
   end

endmodule

/* tb/sorted_value_list_checker.sv */
// Watches both channels of the sorted value list. It keeps its own copy of the
// store, predicts the response to each accepted request, and compares every
// accepted response with the oldest prediction.
module sorted_value_list_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_mode,
   input  logic signed [svl_pkg::DATA_W-1:0]  req_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [svl_pkg::STATUS_W-1:0]       rsp_status,
   input  logic [svl_pkg::COUNT_FIELD_W-1:0]  rsp_count,
   output int                                 mismatch_count,
   output int                                 pending_count
);
   import svl_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      status_type               status;
      logic [COUNT_FIELD_W-1:0] count;
   } outcome_type;

   // Shadow store, ascending
   logic signed [DATA_W-1:0] held_values [CAPACITY];
   int                       held_count;
   outcome_type              due_outcomes [$];

   // Applies one request to the shadow store and returns its response
   function automatic outcome_type apply_request(input logic mode,
                                                 input logic signed [DATA_W-1:0] value);
      outcome_type res;
      int          pos;
      int          i;
      if (mode == MODE_INSERT) begin
         if (held_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // the head is skipped unless strictly greater
            if (held_count == 0 || held_values[0] > value) begin
               pos = 0;
            end else begin
               pos = 1;
               while (pos < held_count && held_values[pos] < value)
                  pos++;
            end
            for (i = held_count; i > pos; i--)
               held_values[i] = held_values[i-1];
            held_values[pos] = value;
            held_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         // first equal entry goes, the gap closes
         pos = 0;
         while (pos < held_count && held_values[pos] != value)
            pos++;
         if (pos >= held_count) begin
            res.status = ST_NOT_FOUND;
         end else begin
            for (i = pos; i + 1 < held_count; i++)
               held_values[i] = held_values[i+1];
            held_count--;
            res.status = ST_DELETED;
         end
      end
      res.count = held_count[COUNT_FIELD_W-1:0];
      return res;
   endfunction

   // Responses are matched before the request of the same edge is queued
   always @(posedge clock) begin : watch
      outcome_type due;
      if (reset) begin
         held_count = 0;
         due_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_outcomes.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected response: status %0d count %0d",
                           rsp_status, rsp_count);
               mismatch_count++;
            end else begin
               due = due_outcomes.pop_front();
               if (rsp_status !== due.status || rsp_count !== due.count) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("response mismatch: status %0d (want %0d) count %0d (want %0d)",
                              rsp_status, due.status, rsp_count, due.count);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            due_outcomes.push_back(apply_request(req_mode, req_value));
      end
      pending_count = due_outcomes.size();
   end

endmodule

/* tb/sorted_value_list_tb.sv */
// Stimulus and verdict for the sorted value list; checking lives in the
// checker module beside the block.
module sorted_value_list_tb;
   import svl_pkg::*;

   localparam int MAX_IDLE     = 18;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASES       = 27;
   localparam int PHASE_LEN    = 50;
   localparam int POOL_SIZE    = 6;
   localparam int DRAIN_CYCLES = 16;
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_mode;
   logic signed [DATA_W-1:0]   req_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [STATUS_W-1:0]        rsp_status;
   logic [COUNT_FIELD_W-1:0]   rsp_count;
   int                         mismatch_count;
   int                         pending_count;
   int                         cycle_count = 0;
   logic                       no_idle = 1'b0;
   logic signed [DATA_W-1:0]   value_pool [POOL_SIZE];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_value_list uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_mode   (req_mode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   sorted_value_list_checker outcome_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // One request: optional gap, then hold until accepted
   task automatic send_request(input logic mode, input logic signed [DATA_W-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off until every response is back
   task automatic drain_requests;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   // Half values from the phase pool so deletes hit, some extremes, the rest noise
   function automatic logic signed [DATA_W-1:0] pick_value;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 62) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // Response side: random stall before each response
   initial begin : response_sink
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int k;
      int phase;
      int n;
      int insert_pct;
      logic mode;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_INSERT;
      req_value = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty delete, extremes, equal head, duplicates, miss
      send_request(MODE_DELETE, '0);
      send_request(MODE_INSERT, '0);
      send_request(MODE_INSERT, '0);
      send_request(MODE_INSERT, VAL_MIN);
      send_request(MODE_INSERT, VAL_MAX);
      send_request(MODE_INSERT, -1);
      send_request(MODE_INSERT, VAL_MIN);
      send_request(MODE_DELETE, 5);
      send_request(MODE_DELETE, '0);
      send_request(MODE_DELETE, VAL_MIN);
      // four held now: fill up, last one refused
      for (k = 0; k <= CAPACITY - 4; k++)
         send_request(MODE_INSERT, k * 7919 - 40000);
      send_request(MODE_DELETE, VAL_MAX);
      send_request(MODE_DELETE, -1);
      drain_requests();

      // Random phases: filling, emptying and balanced mixes
      for (phase = 0; phase < PHASES; phase++) begin
         for (k = 0; k < POOL_SIZE; k++)
            value_pool[k] = ($urandom_range(0, 3) == 0) ? $urandom
                                                        : int'($urandom_range(0, 20)) - 10;
         insert_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 25 : 55;
         no_idle    = (phase % 5 == 2);
         for (n = 0; n < PHASE_LEN; n++) begin
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_DELETE;
            send_request(mode, pick_value());
         end
         if (phase % 9 == 4)
            drain_requests();
      end

      drain_requests();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
